### hdl/assert_macros.svh
// assertion macros used by the activation slot table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define AST_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication out of reset
`define AST_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/ast_pkg.sv
// shared types and constants of the activation slot table
package ast_pkg;

    localparam int ID_W   = 32;
    localparam int ACT_W  = 17;
    localparam int FUNC_W = 2;
    localparam int FSL_W  = 4;
    localparam int DT_W   = 16;
    localparam int CFG_W  = 5;
    localparam int FOC_W  = 5;
    localparam int OCC_W  = 5;
    localparam int IN_W   = 56;
    localparam int OUT_W  = 48;
    localparam int UP_W   = 13;
    localparam int DN_W   = 12;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FOCUS  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_SHIFT = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    localparam logic REG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_W-1:0] SLOT_LIMIT_RST = 5'd7;

    localparam logic [ACT_W-1:0] ACT_ONE    = 17'h10000;
    localparam logic [ACT_W-1:0] LOAD_BOOST = 17'd19661;
    localparam logic [15:0]      RECIP10    = 16'd52429;
    localparam int               UP_SH      = 19;
    localparam int               DN_SH      = 20;
    localparam logic [ACT_W-1:0] UP_BIAS    = 17'd5;
    localparam logic [ACT_W-1:0] DN_BIAS    = 17'd10;
    localparam logic [FOC_W-1:0] FOCUS_NONE = 5'h1F;

    typedef struct packed {
        logic       cap;
        logic [1:0] mode;
        logic       shift_start;
        logic       sel_min;
        logic       boost;
        logic       set_present;
        logic       evict;
        logic       shrink;
        logic       append;
        logic       focus_wr;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              scan_done;
        logic              found;
        logic              full;
        logic              walk_done;
        logic              out_free;
    } t_dp_status;

endpackage

### hdl/activation_slot_table_unit.sv
// activation slot table: top level with stream ports and config register
// load or remove runs a one-slot-per-cycle scan over the occupied slots and then, on a
//   removal hit or an eviction, a shift over the slot memories that closes the gap
// tick walks the occupied slots (one activation update per cycle), focus marks one slot
// a new item is taken only in idle; the next is taken while a result waits
// synchronous active-low reset clears occupancy, focus and sets slot_limit 7
module activation_slot_table_unit import ast_pkg::*; #(
    parameter int MAX_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // trace_id [31:0], focus_slot [35:32], tick_time [51:36], zero fill
    input  logic [IN_W-1:0]   s_axis_tdata,
    // func [1:0]
    input  logic [FUNC_W-1:0] s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // was_present [0], evicted_valid [1], evicted_id [33:2], focus_now [38:34],
    // occupancy [43:39], zero fill
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CFG_W-1:0] r_slot_limit;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_status       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SLOT_LIMIT) ? 32'(r_slot_limit) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RST;
        end else if (cfg_wr && (paddr[2] == REG_SLOT_LIMIT)) begin
            r_slot_limit <= pwdata[CFG_W-1:0];
        end
    end

    ast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ast_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_func    (s_axis_tuser),
        .i_in_id      (s_axis_tdata[31:0]),
        .i_in_fslot   (s_axis_tdata[35:32]),
        .i_in_dt      (s_axis_tdata[51:36]),
        .i_slot_limit (r_slot_limit),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata)
    );

endmodule

### hdl/ast_ctrl.sv
// sequencer that steps the slot table datapath through each item
module ast_ctrl import ast_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_in_func,
    output logic              o_in_ready,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_SHIFT  = 4'd3;
    localparam logic [3:0] ST_SHRINK = 4'd4;
    localparam logic [3:0] ST_APPEND = 4'd5;
    localparam logic [3:0] ST_FOCUS  = 4'd6;
    localparam logic [3:0] ST_TICK   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    unique case (i_in_func)
                        FUNC_LOAD, FUNC_REMOVE: n_state = ST_SCAN;
                        FUNC_FOCUS:             n_state = ST_FOCUS;
                        FUNC_TICK:              n_state = ST_TICK;
                        default:                n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.mode = MODE_SCAN;
                if (i_status.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.func == FUNC_LOAD) begin
                    if (i_status.found) begin
                        o_cmd.boost       = 1'b1;
                        o_cmd.set_present = 1'b1;
                        n_state           = ST_DONE;
                    end else if (i_status.full) begin
                        o_cmd.evict       = 1'b1;
                        o_cmd.shift_start = 1'b1;
                        o_cmd.sel_min     = 1'b1;
                        n_state           = ST_SHIFT;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end else if (i_status.found) begin
                    o_cmd.set_present = 1'b1;
                    o_cmd.shift_start = 1'b1;
                    n_state           = ST_SHIFT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                o_cmd.mode = MODE_SHIFT;
                if (i_status.walk_done) begin
                    n_state = ST_SHRINK;
                end
            end
            ST_SHRINK: begin
                o_cmd.shrink = 1'b1;
                n_state = (i_status.func == FUNC_LOAD) ? ST_APPEND : ST_DONE;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_DONE;
            end
            ST_FOCUS: begin
                o_cmd.focus_wr = 1'b1;
                n_state        = ST_DONE;
            end
            ST_TICK: begin
                o_cmd.mode = MODE_TICK;
                if (i_status.walk_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/ast_dp.sv
// slot memories, counters, search and update datapath of the slot table
module ast_dp import ast_pkg::*; #(
    parameter int MAX_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [FUNC_W-1:0] i_in_func,
    input  logic [ID_W-1:0]   i_in_id,
    input  logic [FSL_W-1:0]  i_in_fslot,
    input  logic [DT_W-1:0]   i_in_dt,
    input  logic [CFG_W-1:0]  i_slot_limit,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [OUT_W-1:0]  o_out_data
);

`include "assert_macros.svh"

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    logic [ID_W-1:0]  mem_id  [MAX_SLOTS];
    logic [ACT_W-1:0] mem_act [MAX_SLOTS];

    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_id;
    logic [FSL_W-1:0]  r_fslot;
    logic [UP_W-1:0]   r_up;
    logic [DN_W-1:0]   r_down;

    logic [CW-1:0]     r_used;
    logic              r_focus_v;
    logic [IW-1:0]     r_focus;

    logic [CW-1:0]     r_ptr;
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic [ID_W-1:0]   r_id_q;
    logic [ACT_W-1:0]  r_act_q;

    logic              r_found;
    logic [IW-1:0]     r_hit_idx;
    logic [ACT_W-1:0]  r_hit_act;
    logic [IW-1:0]     r_min_idx;
    logic [ACT_W-1:0]  r_min_act;
    logic [ID_W-1:0]   r_min_id;
    logic [IW-1:0]     r_base;

    logic              r_present;
    logic              r_ev_valid;
    logic [ID_W-1:0]   r_ev_id;

    logic              r_o_valid;
    logic              r_o_present;
    logic              r_o_ev_valid;
    logic [ID_W-1:0]   r_o_ev_id;
    logic [FOC_W-1:0]  r_o_focus;
    logic [OCC_W-1:0]  r_o_occ;

    // tick step sizes by reciprocal multiply
    logic [ACT_W-1:0]  dt_up;
    logic [ACT_W-1:0]  dt_dn;
    logic [32:0]       up_prod;
    logic [32:0]       dn_prod;

    logic [LW-1:0]     lim_raw;
    logic [LW-1:0]     lim_eff;
    logic [LW-1:0]     used_ext;
    logic              full;
    logic              ptr_lt_used;
    logic              walk_done;

    logic              rd_en;
    logic              we_id;
    logic              we_act;
    logic [IW-1:0]     wa;
    logic [ID_W-1:0]   wd_id;
    logic [ACT_W-1:0]  wd_act;

    logic [ACT_W:0]    boost_sum;
    logic [ACT_W:0]    tick_sum;
    logic [ACT_W-1:0]  tick_val;
    logic [31:0]       fs32;
    logic [IW-1:0]     fs_addr;
    logic              fs_ok;
    logic [IW-1:0]     start_idx;
    logic [31:0]       foc32;
    logic [31:0]       occ32;
    logic [FOC_W-1:0]  foc_now;

    assign dt_up   = ACT_W'(i_in_dt) + UP_BIAS;
    assign dt_dn   = ACT_W'(i_in_dt) + DN_BIAS;
    assign up_prod = 33'(dt_up) * 33'(RECIP10);
    assign dn_prod = 33'(dt_dn) * 33'(RECIP10);

    assign lim_raw  = LW'(i_slot_limit);
    assign used_ext = LW'(r_used);
    always_comb begin
        lim_eff = lim_raw;
        if (lim_raw == '0) begin
            lim_eff = LW'(1);
        end else if (lim_raw > LW'(MAX_SLOTS)) begin
            lim_eff = LW'(MAX_SLOTS);
        end
    end
    assign full = (used_ext >= lim_eff) && (r_used != '0);

    assign ptr_lt_used = (r_ptr < r_used);
    assign walk_done   = !ptr_lt_used && !r_pv;

    assign o_status.func      = r_func;
    assign o_status.scan_done = r_found || walk_done;
    assign o_status.found     = r_found;
    assign o_status.full      = full;
    assign o_status.walk_done = walk_done;
    assign o_status.out_free  = !r_o_valid || i_out_ready;

    assign fs32      = 32'(r_fslot);
    assign fs_addr   = fs32[IW-1:0];
    assign fs_ok     = (fs32 < 32'(r_used));
    assign start_idx = i_cmd.sel_min ? r_min_idx : r_hit_idx;

    assign boost_sum = {1'b0, r_hit_act} + {1'b0, LOAD_BOOST};
    assign tick_sum  = {1'b0, r_act_q} + (ACT_W + 1)'(r_up);

    always_comb begin
        if (r_focus_v && (r_pidx == r_focus)) begin
            tick_val = (tick_sum > {1'b0, ACT_ONE}) ? ACT_ONE : tick_sum[ACT_W-1:0];
        end else if (r_act_q > ACT_W'(r_down)) begin
            tick_val = r_act_q - ACT_W'(r_down);
        end else begin
            tick_val = '0;
        end
    end

    always_comb begin
        rd_en = 1'b0;
        unique case (i_cmd.mode)
            MODE_SCAN:             rd_en = ptr_lt_used && !r_found;
            MODE_SHIFT, MODE_TICK: rd_en = ptr_lt_used;
            MODE_IDLE:             rd_en = 1'b0;
            default:               rd_en = 1'b0;
        endcase
    end

    always_comb begin
        we_id  = 1'b0;
        we_act = 1'b0;
        wa     = r_pidx;
        wd_id  = r_id_q;
        wd_act = r_act_q;
        priority if (r_pv && (i_cmd.mode == MODE_SHIFT)) begin
            we_id  = 1'b1;
            we_act = 1'b1;
            wa     = r_pidx - IW'(1);
        end else if (r_pv && (i_cmd.mode == MODE_TICK)) begin
            we_act = 1'b1;
            wd_act = tick_val;
        end else if (i_cmd.boost) begin
            we_act = 1'b1;
            wa     = r_hit_idx;
            wd_act = (boost_sum > {1'b0, ACT_ONE}) ? ACT_ONE : boost_sum[ACT_W-1:0];
        end else if (i_cmd.append) begin
            we_id  = 1'b1;
            we_act = 1'b1;
            wa     = r_used[IW-1:0];
            wd_id  = r_id;
            wd_act = ACT_ONE;
        end else if (i_cmd.focus_wr && fs_ok) begin
            we_act = 1'b1;
            wa     = fs_addr;
            wd_act = ACT_ONE;
        end else begin
            we_id  = 1'b0;
            we_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_id) begin
            mem_id[wa] <= wd_id;
        end
        if (we_act) begin
            mem_act[wa] <= wd_act;
        end
        if (rd_en) begin
            r_id_q  <= mem_id[r_ptr[IW-1:0]];
            r_act_q <= mem_act[r_ptr[IW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func     <= i_in_func;
            r_id       <= i_in_id;
            r_fslot    <= i_in_fslot;
            r_up       <= up_prod[UP_SH +: UP_W];
            r_down     <= dn_prod[DN_SH +: DN_W];
            r_present  <= 1'b0;
            r_ev_valid <= 1'b0;
            r_ev_id    <= '0;
        end
        if (rd_en) begin
            r_pidx <= r_ptr[IW-1:0];
        end
        if ((i_cmd.mode == MODE_SCAN) && r_pv && !r_found) begin
            if (r_id_q == r_id) begin
                r_hit_idx <= r_pidx;
                r_hit_act <= r_act_q;
            end
            if ((r_pidx == '0) || (r_act_q < r_min_act)) begin
                r_min_idx <= r_pidx;
                r_min_act <= r_act_q;
                r_min_id  <= r_id_q;
            end
        end
        if (i_cmd.shift_start) begin
            r_base <= start_idx;
        end
        if (i_cmd.set_present) begin
            r_present <= 1'b1;
        end
        if (i_cmd.evict) begin
            r_ev_valid <= 1'b1;
            r_ev_id    <= r_min_id;
        end
        if (i_cmd.emit) begin
            r_o_present  <= r_present;
            r_o_ev_valid <= r_ev_valid;
            r_o_ev_id    <= r_ev_id;
            r_o_focus    <= foc_now;
            r_o_occ      <= occ32[OCC_W-1:0];
        end
    end

    assign foc32   = 32'(r_focus);
    assign occ32   = 32'(r_used);
    assign foc_now = r_focus_v ? foc32[FOC_W-1:0] : FOCUS_NONE;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_focus_v <= 1'b0;
            r_focus   <= '0;
            r_ptr     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pv <= rd_en;
            if (rd_en) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.cap) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.shift_start) begin
                r_ptr <= CW'(start_idx) + CW'(1);
            end
            if ((i_cmd.mode == MODE_SCAN) && r_pv && !r_found && (r_id_q == r_id)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.shrink) begin
                r_used <= r_used - CW'(1);
                if (r_focus_v && (r_focus >= r_base)) begin
                    if (r_focus == '0) begin
                        // eviction keeps the focus at slot zero, remove drops it
                        if (r_func != FUNC_LOAD) begin
                            r_focus_v <= 1'b0;
                        end
                    end else begin
                        r_focus <= r_focus - IW'(1);
                    end
                end
            end
            if (i_cmd.append) begin
                r_used <= r_used + CW'(1);
            end
            if (i_cmd.focus_wr && fs_ok) begin
                r_focus_v <= 1'b1;
                r_focus   <= fs_addr;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = {{(OUT_W - OCC_W - FOC_W - ID_W - 2){1'b0}},
                          r_o_occ, r_o_focus, r_o_ev_id, r_o_ev_valid, r_o_present};

    `AST_ALWAYS(a_used_max, i_clk, i_rst_n, r_used <= CW'(MAX_SLOTS), "occupancy above table size")
    `AST_IMPLY(a_focus_in_table, i_clk, i_rst_n, i_cmd.emit && r_focus_v, CW'(r_focus) < r_used, "focus beyond occupied slots")
    `AST_IMPLY(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_o_valid || i_out_ready, "result overwrites a waiting item")
    `AST_IMPLY(a_one_outcome, i_clk, i_rst_n, r_o_valid, !(r_o_present && r_o_ev_valid), "hit and eviction in one item")

endmodule

### tb/activation_slot_table_unit_tb.sv
// self-checking testbench for the activation slot table: stream traffic with config phases
module activation_slot_table_unit_tb;
    import ast_pkg::*;

    localparam int MAX_SLOTS = 16;
    localparam int SETTLE_CYCLES = 2 * MAX_SLOTS + 8;

    typedef struct packed {
        logic             present;
        logic             ev_valid;
        logic [ID_W-1:0]  ev_id;
        logic [FOC_W-1:0] focus;
        logic [OCC_W-1:0] occ;
    } t_slot_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [FUNC_W-1:0] s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // local copy of the slot table
    logic [ID_W-1:0]  tbl_id [MAX_SLOTS];
    logic [ACT_W-1:0] tbl_act [MAX_SLOTS];
    int               tbl_used = 0;
    int               tbl_focus = -1;
    logic [CFG_W-1:0] cur_limit = SLOT_LIMIT_RST;

    t_slot_result pending_results[$];
    int idle_pct = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int evictions_seen = 0;
    int limit_settings = 0;

    activation_slot_table_unit #(.MAX_SLOTS(MAX_SLOTS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("activation_slot_table_unit verification failed");
        $finish;
    end

    function automatic void drop_slot(int idx);
        for (int k = idx; k + 1 < tbl_used; k++) begin
            tbl_id[k] = tbl_id[k + 1];
            tbl_act[k] = tbl_act[k + 1];
        end
        tbl_used--;
    endfunction

    function automatic t_slot_result table_step(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                                logic [FSL_W-1:0] fslot, logic [DT_W-1:0] dt);
        t_slot_result r;
        int hit;
        int lim;
        int low_i;
        logic [31:0] sum;
        logic [31:0] up;
        logic [31:0] down;
        r = '0;
        hit = -1;
        for (int k = 0; k < tbl_used; k++)
            if (hit < 0 && tbl_id[k] == id) hit = k;
        lim = int'(cur_limit);
        if (lim < 1) lim = 1;
        if (lim > MAX_SLOTS) lim = MAX_SLOTS;
        case (fn)
            FUNC_LOAD: begin
                if (hit >= 0) begin
                    sum = 32'(tbl_act[hit]) + 32'(LOAD_BOOST);
                    tbl_act[hit] = (sum > 32'(ACT_ONE)) ? ACT_ONE : ACT_W'(sum);
                    r.present = 1'b1;
                end else begin
                    if (tbl_used >= lim && tbl_used > 0) begin
                        low_i = 0;
                        for (int k = 1; k < tbl_used; k++)
                            if (tbl_act[k] < tbl_act[low_i]) low_i = k;
                        r.ev_valid = 1'b1;
                        r.ev_id = tbl_id[low_i];
                        drop_slot(low_i);
                        if (tbl_focus >= low_i) tbl_focus = (tbl_focus < 1) ? 0 : tbl_focus - 1;
                    end
                    if (tbl_used < MAX_SLOTS) begin
                        tbl_id[tbl_used] = id;
                        tbl_act[tbl_used] = ACT_ONE;
                        tbl_used++;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (hit >= 0) begin
                    r.present = 1'b1;
                    drop_slot(hit);
                    if (tbl_focus >= hit) tbl_focus = tbl_focus - 1;
                end
            end
            FUNC_FOCUS: begin
                if (int'(fslot) < tbl_used) begin
                    tbl_focus = int'(fslot);
                    tbl_act[fslot] = ACT_ONE;
                end
            end
            default: begin
                up = (32'(dt) + 32'd5) / 32'd10;
                down = (32'(dt) + 32'd10) / 32'd20;
                for (int k = 0; k < tbl_used; k++) begin
                    if (k == tbl_focus) begin
                        sum = 32'(tbl_act[k]) + up;
                        tbl_act[k] = (sum > 32'(ACT_ONE)) ? ACT_ONE : ACT_W'(sum);
                    end else begin
                        tbl_act[k] = (32'(tbl_act[k]) > down) ? ACT_W'(32'(tbl_act[k]) - down) : '0;
                    end
                end
            end
        endcase
        r.focus = FOC_W'(tbl_focus);
        r.occ = OCC_W'(tbl_used);
        return r;
    endfunction

    // receiver side with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 7);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.present = m_axis_tdata[0];
            got.ev_valid = m_axis_tdata[1];
            got.ev_id = m_axis_tdata[33:2];
            got.focus = m_axis_tdata[38:34];
            got.occ = m_axis_tdata[43:39];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: present %0b evicted %0b id %h focus %0d occ %0d",
                             got.present, got.ev_valid, got.ev_id, got.focus, got.occ);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.present !== want.present || got.ev_valid !== want.ev_valid ||
                    got.ev_id !== want.ev_id || got.focus !== want.focus ||
                    got.occ !== want.occ) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d", results_checked);
                        $display("  expected: present %0b evicted %0b id %h focus %0d occ %0d",
                                 want.present, want.ev_valid, want.ev_id, want.focus, want.occ);
                        $display("  actual:   present %0b evicted %0b id %h focus %0d occ %0d",
                                 got.present, got.ev_valid, got.ev_id, got.focus, got.occ);
                    end
                end else if (got.ev_valid) begin
                    evictions_seen++;
                end
            end
        end
    end

    task automatic send_op(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                           logic [FSL_W-1:0] fslot, logic [DT_W-1:0] dt);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {4'b0, dt, fslot, id};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(table_step(fn, id, fslot, dt));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slot_limit(logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(REG_SLOT_LIMIT));
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_limit = value;
        limit_settings++;
    endtask

    task automatic send_random_items(int count);
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0] id;
        logic [FSL_W-1:0] fslot;
        logic [DT_W-1:0] dt;
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            fn = (pick < 40) ? FUNC_LOAD : (pick < 60) ? FUNC_REMOVE :
                 (pick < 80) ? FUNC_FOCUS : FUNC_TICK;
            id = $urandom;
            pick = $urandom_range(0, 99);
            if (tbl_used > 0 && pick < ((fn == FUNC_REMOVE) ? 70 : 45))
                id = tbl_id[$urandom_range(0, tbl_used - 1)];
            else if (pick < 60)
                id = $urandom_range(0, 7);
            fslot = FSL_W'($urandom_range(0, 15));
            if (tbl_used > 0 && $urandom_range(0, 3) != 0)
                fslot = FSL_W'($urandom_range(0, tbl_used - 1));
            case ($urandom_range(0, 7))
                0: dt = '1;
                1: dt = '0;
                2, 3: dt = DT_W'($urandom);
                default: dt = DT_W'($urandom_range(0, 3000));
            endcase
            send_op(fn, id, fslot, dt);
        end
    endtask

    task automatic test_directed_ops();
        idle_pct = 30;
        send_op(FUNC_REMOVE, 32'h1234_5678, 4'd0, 16'd0);
        send_op(FUNC_FOCUS, 32'h0, 4'd0, 16'd0);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'hFFFF);
        send_op(FUNC_LOAD, 32'h0000_0000, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
        send_op(FUNC_LOAD, 32'hFFFF_FFFF, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'hA5A5_A5A5, 4'd0, 16'd0);
        send_op(FUNC_FOCUS, 32'h0, 4'd1, 16'd0);
        send_op(FUNC_FOCUS, 32'h0, 4'hF, 16'd0);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'hFFFF);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'h0000_0000, 4'd0, 16'd0);
        // removal below the focus pulls it down, then off the table
        send_op(FUNC_REMOVE, 32'h0000_0000, 4'd0, 16'd0);
        send_op(FUNC_REMOVE, 32'hFFFF_FFFF, 4'd0, 16'd0);
        for (int k = 1; k <= 6; k++)
            send_op(FUNC_LOAD, 32'(k * 32'h11), 4'd0, 16'd0);
        send_op(FUNC_FOCUS, 32'h0, 4'd3, 16'd0);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'd40000);
        send_op(FUNC_LOAD, 32'h77, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'h88, 4'd0, 16'd0);
    endtask

    task automatic test_limit_extremes();
        wait_results_drained();
        write_slot_limit(5'd16);
        for (int k = 0; k < 17; k++)
            send_op(FUNC_LOAD, {8'hC0, 24'(k)}, 4'd0, 16'd0);
        // once the activations all tie, the focused first slot is evicted and focus holds at 0
        send_op(FUNC_FOCUS, 32'h0, 4'd0, 16'd0);
        wait_results_drained();
        write_slot_limit(5'd1);
        send_op(FUNC_LOAD, 32'hD000_0001, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'hD000_0002, 4'd0, 16'd0);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'd20000);
        wait_results_drained();
        write_slot_limit(5'd0);
        send_op(FUNC_LOAD, 32'hD000_0003, 4'd0, 16'd0);
        send_op(FUNC_LOAD, 32'hD000_0004, 4'd0, 16'd0);
        wait_results_drained();
        write_slot_limit(5'd31);
        send_op(FUNC_FOCUS, 32'h0, 4'hF, 16'd0);
        send_op(FUNC_LOAD, 32'hD000_0005, 4'd0, 16'd0);
        send_op(FUNC_TICK, 32'h0, 4'd0, 16'hFFFF);
        send_op(FUNC_LOAD, 32'hD000_0005, 4'd0, 16'd0);
        send_op(FUNC_REMOVE, 32'hD000_0005, 4'd0, 16'd0);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] limits [9] = '{5'd2, 5'd0, 5'd16, 5'd5, 5'd31, 5'd1, 5'd9,
                                         5'd17, 5'd12};
        foreach (limits[p]) begin
            wait_results_drained();
            write_slot_limit(limits[p]);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            send_random_items(90);
            wait_results_drained();
            send_random_items(90);
        end
    endtask

    task automatic test_steady_stream();
        wait_results_drained();
        idle_pct = 0;
        write_slot_limit(5'($urandom_range(3, 14)));
        send_random_items(180);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_limit_extremes();
        test_random_traffic();
        test_steady_stream();
        wait_results_drained();
        $display("%0d items sent, %0d results checked, %0d evictions", items_sent,
                 results_checked, evictions_seen);
        $display("%0d slot limit settings, loads, removes, focus and ticks mixed", limit_settings);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("activation_slot_table_unit verification clean");
        end else begin
            $display("activation_slot_table_unit verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ast_pkg.sv
hdl/ast_ctrl.sv
hdl/ast_dp.sv
hdl/activation_slot_table_unit.sv
tb/activation_slot_table_unit_tb.sv
